@@ sv/upload_retry_tracker_assert.svh @@
// Assertion macros used by the tracker top level.
// Define ASSERT_OFF to compile every assertion away.
`ifndef UPLOAD_RETRY_TRACKER_ASSERT_SVH
`define UPLOAD_RETRY_TRACKER_ASSERT_SVH

`ifndef ASSERT_OFF
`define URT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define URT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define URT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define URT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ sv/urt_pkg.sv @@
`default_nettype none

package urt_pkg;

	// Queue capacity; a reported depth above it is invalid.
	localparam logic [7:0] FIFO_CAPACITY = 8'd32;
	localparam logic [2:0] EXP_CAP = 3'd7;

	localparam logic [63:0] NO_TIME  = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] TIME_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	// Commands.
	localparam logic [1:0] CMD_ENQUEUE  = 2'd0;
	localparam logic [1:0] CMD_BEGIN    = 2'd1;
	localparam logic [1:0] CMD_RESPONSE = 2'd2;

	// Response dispositions.
	localparam logic [1:0] DISP_ACK        = 2'd0;
	localparam logic [1:0] DISP_RETRY      = 2'd1;
	localparam logic [1:0] DISP_QUARANTINE = 2'd2;

	// Queue actions reported with a response.
	localparam logic [1:0] QA_UNCHANGED   = 2'd0;
	localparam logic [1:0] QA_POPPED      = 2'd1;
	localparam logic [1:0] QA_QUARANTINED = 2'd2;

	// Response outcomes.
	localparam logic [1:0] OUT_IGNORED     = 2'd0;
	localparam logic [1:0] OUT_ACKED       = 2'd1;
	localparam logic [1:0] OUT_RETRY       = 2'd2;
	localparam logic [1:0] OUT_QUARANTINED = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_MAX_PAYLOAD_LEN = 2'd0;
	localparam logic [1:0] REG_BASE_DELAY_MS   = 2'd1;
	localparam logic [1:0] REG_MAX_DELAY_MS    = 2'd2;
	localparam logic [1:0] REG_JITTER_MASK     = 2'd3;

	// Event counter slots.
	localparam logic [2:0] CNT_ENQUEUED   = 3'd0;
	localparam logic [2:0] CNT_OVERFLOW   = 3'd1;
	localparam logic [2:0] CNT_ACK        = 3'd2;
	localparam logic [2:0] CNT_RETRY      = 3'd3;
	localparam logic [2:0] CNT_QUARANTINE = 3'd4;
	localparam int         NUM_COUNTERS   = 5;

	// HTTP status bounds.
	localparam logic [9:0] HTTP_OK_LO          = 10'd200;
	localparam logic [9:0] HTTP_OK_HI          = 10'd299;
	localparam logic [9:0] HTTP_CLIENT_LO      = 10'd400;
	localparam logic [9:0] HTTP_CLIENT_HI      = 10'd499;
	localparam logic [9:0] HTTP_TIMEOUT        = 10'd408;
	localparam logic [9:0] HTTP_TOO_MANY       = 10'd429;

	localparam logic [15:0] MIN_PAYLOAD_LEN = 16'd2;

	typedef struct packed {
		logic [15:0] max_payload_len;
		logic [15:0] base_delay_ms;
		logic [31:0] max_delay_ms;
		logic [31:0] jitter_mask;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] seq_id;
		logic [31:0] payload_crc;
		logic        oldest_lost;
		logic [7:0]  depth_now;
		logic [15:0] payload_len;
		logic [1:0]  disposition;
		logic [9:0]  http_status;
		logic [1:0]  queue_action;
		logic [31:0] random_word;
		logic [63:0] time_ms;
	} item_t;

	typedef struct packed {
		logic                         accepted;
		logic [1:0]                   outcome;
		logic                         busy;
		logic [2:0]                   backoff_level;
		logic [63:0]                  next_try;
		logic [7:0]                   depth_seen;
		logic [NUM_COUNTERS-1:0][31:0] counters;
		logic [62:0]                  last_ok;
	} result_t;

endpackage

`default_nettype wire

@@ sv/upload_retry_tracker.sv @@
// Channel   Direction  Handshake             Contents
// input     in         in_valid / in_stall   command and its fields, one transaction each
// result    out        out_valid / out_stall one result per input transaction
// config    in         cfg_valid / cfg_ready register index and write data
//
// Each input transaction is captured in an input register, then decided against the
// tracker state and written to the result register; one transaction is taken in
// every cycle while in_stall is low.
// The only limit on rate is the result register: while it holds an untaken
// result, the input register waits and in_stall is raised.
// Reset is asynchronous and active low; it clears all tracker state and loads
// the register defaults. Configuration writes are always taken (cfg_ready is high).
`default_nettype none

`include "upload_retry_tracker_assert.svh"

module upload_retry_tracker import urt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         command,
	input  wire logic [31:0]        seq_id,
	input  wire logic [31:0]        payload_crc,
	input  wire logic               oldest_lost,
	input  wire logic [7:0]         depth_now,
	input  wire logic [15:0]        payload_len,
	input  wire logic [1:0]         disposition,
	input  wire logic [9:0]         http_status,
	input  wire logic [1:0]         queue_action,
	input  wire logic [31:0]        random_word,
	input  wire logic signed [63:0] time_ms,

	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    accepted,
	output logic [1:0]              outcome,
	output logic                    busy_res,
	output logic [2:0]              backoff_level,
	output logic signed [63:0]      next_try_ms,
	output logic [7:0]              depth_seen,
	output logic [31:0]             enqueued_total,
	output logic [31:0]             overflow_total,
	output logic [31:0]             ack_total,
	output logic [31:0]             retry_total,
	output logic [31:0]             quarantine_total,
	output logic [62:0]             last_ok_ms,

	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_q;
	logic    out_valid_q;
	result_t result;
	logic    advance;
	logic    in_fire;

	// Configuration registers; every index names a register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_payload_len <= 16'd4096;
			cfg_q.base_delay_ms <= 16'd1000;
			cfg_q.max_delay_ms <= 32'd128000;
			cfg_q.jitter_mask <= 32'd1023;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAX_PAYLOAD_LEN: cfg_q.max_payload_len <= cfg_data[15:0];
				REG_BASE_DELAY_MS:   cfg_q.base_delay_ms <= cfg_data[15:0];
				REG_MAX_DELAY_MS:    cfg_q.max_delay_ms <= cfg_data;
				REG_JITTER_MASK:     cfg_q.jitter_mask <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The held transaction moves on whenever the result register is free or
	// being emptied in this cycle.
	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_fire = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= in_fire || (valid_s1 && !advance);
			out_valid_q <= advance || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.command <= command;
			item_s1.seq_id <= seq_id;
			item_s1.payload_crc <= payload_crc;
			item_s1.oldest_lost <= oldest_lost;
			item_s1.depth_now <= depth_now;
			item_s1.payload_len <= payload_len;
			item_s1.disposition <= disposition;
			item_s1.http_status <= http_status;
			item_s1.queue_action <= queue_action;
			item_s1.random_word <= random_word;
			item_s1.time_ms <= time_ms;
		end
		if (advance) begin
			res_q <= result;
		end
	end

	// State update and result for the held transaction; state commits when it advances.
	urt_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.cfg    (cfg_q),
		.item   (item_s1),
		.result (result)
	);

	assign out_valid = out_valid_q;
	assign accepted = res_q.accepted;
	assign outcome = res_q.outcome;
	assign busy_res = res_q.busy;
	assign backoff_level = res_q.backoff_level;
	assign next_try_ms = signed'(res_q.next_try);
	assign depth_seen = res_q.depth_seen;
	assign enqueued_total = res_q.counters[CNT_ENQUEUED];
	assign overflow_total = res_q.counters[CNT_OVERFLOW];
	assign ack_total = res_q.counters[CNT_ACK];
	assign retry_total = res_q.counters[CNT_RETRY];
	assign quarantine_total = res_q.counters[CNT_QUARANTINE];
	assign last_ok_ms = res_q.last_ok;

	// The input side only waits on a result that is blocked downstream.
	`URT_ASSERT_IMPLY(a_stall_needs_blocked_out, clk, arst_n, in_stall, out_valid_q && out_stall, "input stalled without a blocked result")
	// A nonzero backoff only exists together with a scheduled retry time.
	`URT_ASSERT_IMPLY(a_backoff_has_time, clk, arst_n, out_valid_q && res_q.backoff_level != 3'd0, res_q.next_try != NO_TIME, "backoff level without retry time")
	// A request in flight always carries a non-negative attempt time.
	`URT_ASSERT_IMPLY(a_busy_has_time, clk, arst_n, out_valid_q && res_q.busy, !res_q.next_try[63], "in-flight request without attempt time")
	// Every overflow is also counted as an enqueue notice.
	`URT_ASSERT_IMPLY(a_overflow_le_enqueued, clk, arst_n, out_valid_q, res_q.counters[CNT_OVERFLOW] <= res_q.counters[CNT_ENQUEUED], "overflow count exceeds enqueue count")

endmodule

`default_nettype wire

@@ sv/urt_delay.sv @@
`default_nettype none

// Retry time: now + min(base << exp, max) + (random & mask), saturating.
module urt_delay import urt_pkg::*; (
	input  wire cfg_t        cfg,
	input  wire logic [2:0]  exp_level,
	input  wire logic [31:0] random_word,
	input  wire logic [63:0] now,
	output logic [63:0]      next_try
);

	logic [22:0] shifted;
	logic [31:0] capped;
	logic [32:0] delay;
	logic [63:0] sum;

	always_comb begin
		shifted = {7'd0, cfg.base_delay_ms} << exp_level;
		capped = ({9'd0, shifted} > cfg.max_delay_ms) ? cfg.max_delay_ms : {9'd0, shifted};
		delay = {1'b0, capped} + {1'b0, random_word & cfg.jitter_mask};
		// The time is non-negative here, so the sum cannot pass 2^64.
		sum = now + {31'd0, delay};
		next_try = sum[63] ? TIME_MAX : sum;
	end

endmodule

`default_nettype wire

@@ sv/urt_tracker.sv @@
`default_nettype none

// Tracker state and the per-transaction decision logic.
module urt_tracker import urt_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  fire,
	input  wire cfg_t  cfg,
	input  wire item_t item,
	output result_t    result
);

	logic [31:0] held_seq_q, held_crc_q;
	logic [63:0] next_attempt_q;
	logic [2:0]  exp_q;
	logic        busy_q, orphan_q;
	logic [7:0]  depth_q;
	logic [31:0] cnt_q [NUM_COUNTERS];
	logic [62:0] last_ok_q;

	logic [31:0] held_seq_d, held_crc_d;
	logic [63:0] next_attempt_d;
	logic [2:0]  exp_d;
	logic        busy_d, orphan_d;
	logic [7:0]  depth_d;
	logic [NUM_COUNTERS-1:0] inc;
	logic [62:0] last_ok_d;
	logic        acc;
	logic [1:0]  oc;

	logic        depth_ok, depth_nz, now_neg, match;
	logic        enq_ok, begin_ok, contract_ok, removal_ok, resp_ok;
	logic        st_ok, st_client;
	logic [63:0] retry_time;

	urt_delay u_delay (
		.cfg         (cfg),
		.exp_level   (exp_q),
		.random_word (item.random_word),
		.now         (item.time_ms),
		.next_try    (retry_time)
	);

	always_comb begin
		depth_ok = item.depth_now <= FIFO_CAPACITY;
		depth_nz = item.depth_now != 8'd0;
		now_neg = item.time_ms[63];
		match = (held_seq_q == item.seq_id) && (held_crc_q == item.payload_crc);

		enq_ok = depth_nz && depth_ok &&
			(item.oldest_lost ? (item.seq_id != 32'd0)
				: (item.seq_id == 32'd0 && item.payload_crc == 32'd0));
		begin_ok = (item.seq_id != 32'd0) && (item.payload_len >= MIN_PAYLOAD_LEN) &&
			(item.payload_len <= cfg.max_payload_len) && depth_nz && depth_ok && !now_neg;

		st_ok = item.http_status >= HTTP_OK_LO && item.http_status <= HTTP_OK_HI;
		st_client = item.http_status >= HTTP_CLIENT_LO && item.http_status <= HTTP_CLIENT_HI &&
			item.http_status != HTTP_TIMEOUT && item.http_status != HTTP_TOO_MANY;
		case (item.disposition)
			DISP_ACK:        contract_ok = st_ok && item.queue_action != QA_QUARANTINED;
			DISP_RETRY:      contract_ok = item.queue_action == QA_UNCHANGED;
			DISP_QUARANTINE: contract_ok = st_client && item.queue_action != QA_POPPED;
			default:         contract_ok = 1'b0;
		endcase
		if (item.queue_action != QA_UNCHANGED && item.queue_action != QA_POPPED &&
			item.queue_action != QA_QUARANTINED) begin
			contract_ok = 1'b0;
		end

		if (item.disposition == DISP_RETRY) begin
			removal_ok = 1'b1;
		end else if (orphan_q) begin
			removal_ok = item.queue_action == QA_UNCHANGED;
		end else if (item.disposition == DISP_ACK) begin
			removal_ok = item.queue_action == QA_POPPED;
		end else begin
			removal_ok = item.queue_action == QA_QUARANTINED;
		end

		resp_ok = busy_q && (item.seq_id != 32'd0) && match && depth_ok && !now_neg &&
			contract_ok && removal_ok;

		held_seq_d = held_seq_q;
		held_crc_d = held_crc_q;
		next_attempt_d = next_attempt_q;
		exp_d = exp_q;
		busy_d = busy_q;
		orphan_d = orphan_q;
		depth_d = depth_q;
		inc = '0;
		last_ok_d = last_ok_q;
		acc = 1'b0;
		oc = OUT_IGNORED;

		case (item.command)
			CMD_ENQUEUE: begin
				if (enq_ok) begin
					acc = 1'b1;
					depth_d = item.depth_now;
					inc[CNT_ENQUEUED] = 1'b1;
					if (item.oldest_lost) begin
						inc[CNT_OVERFLOW] = 1'b1;
						if (match) begin
							if (busy_q) begin
								orphan_d = 1'b1;
							end else begin
								held_seq_d = 32'd0;
								held_crc_d = 32'd0;
								next_attempt_d = NO_TIME;
								exp_d = 3'd0;
								orphan_d = 1'b0;
							end
						end
					end
				end
			end
			CMD_BEGIN: begin
				if (begin_ok) begin
					depth_d = item.depth_now;
					if (!busy_q) begin
						if (held_seq_q != 32'd0 && match) begin
							// Retry of the held request once its backoff has run out.
							if (!orphan_q && !next_attempt_q[63] &&
								item.time_ms >= next_attempt_q) begin
								busy_d = 1'b1;
								acc = 1'b1;
							end
						end else begin
							held_seq_d = item.seq_id;
							held_crc_d = item.payload_crc;
							next_attempt_d = item.time_ms;
							exp_d = 3'd0;
							busy_d = 1'b1;
							orphan_d = 1'b0;
							acc = 1'b1;
						end
					end
				end
			end
			CMD_RESPONSE: begin
				if (resp_ok) begin
					depth_d = item.depth_now;
					if (item.disposition == DISP_RETRY && !orphan_q) begin
						inc[CNT_RETRY] = 1'b1;
						busy_d = 1'b0;
						next_attempt_d = retry_time;
						if (exp_q != EXP_CAP) begin
							exp_d = exp_q + 3'd1;
						end
						oc = OUT_RETRY;
					end else begin
						held_seq_d = 32'd0;
						held_crc_d = 32'd0;
						next_attempt_d = NO_TIME;
						exp_d = 3'd0;
						busy_d = 1'b0;
						orphan_d = 1'b0;
						case (item.disposition)
							DISP_ACK: begin
								inc[CNT_ACK] = 1'b1;
								last_ok_d = item.time_ms[62:0];
								oc = OUT_ACKED;
							end
							DISP_RETRY: begin
								inc[CNT_RETRY] = 1'b1;
								oc = OUT_RETRY;
							end
							default: begin
								inc[CNT_QUARANTINE] = item.queue_action == QA_QUARANTINED;
								oc = OUT_QUARANTINED;
							end
						endcase
					end
				end
			end
			default: begin
			end
		endcase

		result.accepted = acc;
		result.outcome = oc;
		result.busy = busy_d;
		result.backoff_level = exp_d;
		result.next_try = next_attempt_d;
		result.depth_seen = depth_d;
		for (int k = 0; k < NUM_COUNTERS; k++) begin
			result.counters[k] = (inc[k] && cnt_q[k] != 32'hFFFF_FFFF) ?
				cnt_q[k] + 32'd1 : cnt_q[k];
		end
		result.last_ok = last_ok_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_seq_q <= 32'd0;
			held_crc_q <= 32'd0;
			next_attempt_q <= NO_TIME;
			exp_q <= 3'd0;
			busy_q <= 1'b0;
			orphan_q <= 1'b0;
			depth_q <= 8'd0;
			for (int k = 0; k < NUM_COUNTERS; k++) begin
				cnt_q[k] <= 32'd0;
			end
			last_ok_q <= 63'd0;
		end else if (fire) begin
			held_seq_q <= held_seq_d;
			held_crc_q <= held_crc_d;
			next_attempt_q <= next_attempt_d;
			exp_q <= exp_d;
			busy_q <= busy_d;
			orphan_q <= orphan_d;
			depth_q <= depth_d;
			for (int k = 0; k < NUM_COUNTERS; k++) begin
				cnt_q[k] <= result.counters[k];
			end
			last_ok_q <= last_ok_d;
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/tb_upload_retry_tracker.sv @@
`timescale 1ns / 1ps

// Testbench for the upload retry tracker. A driver and a monitor run as clocked always
// blocks. The driver takes commands from a backlog that the stimulus process fills, and
// the monitor checks every result against the tracker state kept here.
module tb_upload_retry_tracker;
	import urt_pkg::*;

	// Codes that the package leaves unnamed because the block treats them as invalid.
	localparam logic [1:0] CMD_UNKNOWN  = 2'd3;
	localparam logic [1:0] DISP_INVALID = 2'd3;
	localparam logic [1:0] QA_INVALID   = 2'd3;

	localparam logic [9:0] STATUS_TOP = 10'd999;
	localparam int CYCLE_LIMIT = 200000;
	// The result count at which the receiver stops taking results, and for how long.
	localparam int HOLD_AFTER  = 150;
	localparam int HOLD_CYCLES = 300;
	localparam int END_CYCLES  = 10;

	localparam logic [31:0] SEQ_A = 32'h1357_9bdf;
	localparam logic [31:0] CRC_A = 32'h0f1e_2d3c;
	localparam logic [31:0] SEQ_B = 32'h0000_0042;
	localparam logic [31:0] CRC_B = 32'h8421_7777;
	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Every input of the block starts at a known value.
	logic in_valid = 1'b0;
	item_t drv = '0;
	logic out_stall = 1'b0;
	logic cfg_valid = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	logic in_stall, out_valid, cfg_ready;
	logic accepted, busy_res;
	logic [1:0] outcome;
	logic [2:0] backoff_level;
	logic signed [63:0] next_try_ms;
	logic [7:0] depth_seen;
	logic [31:0] enqueued_total, overflow_total, ack_total, retry_total, quarantine_total;
	logic [62:0] last_ok_ms;

	// Commands waiting to be driven, and the results the tracker owes us, oldest first.
	item_t cmd_backlog[$];
	result_t reports_due[$];
	int queued_total = 0;
	int reports_seen = 0;
	int errors = 0;
	int cycle_count = 0;
	bit no_gaps = 1'b0;

	// Our copy of the tracker: the configuration registers and the request state.
	cfg_t tracker_cfg = '{max_payload_len: 16'd4096, base_delay_ms: 16'd1000,
		max_delay_ms: 32'd128000, jitter_mask: 32'd1023};
	logic [31:0] sel_seq = '0;
	logic [31:0] sel_crc = '0;
	logic [63:0] retry_at = NO_TIME;
	logic [2:0] retry_exp = '0;
	logic req_busy = 1'b0;
	logic orphaned_req = 1'b0;
	logic [7:0] depth_rec = '0;
	logic [NUM_COUNTERS-1:0][31:0] evt_cnt = '0;
	logic [63:0] last_ack_ms = '0;

	// Time base of the generated commands; it only moves forward within one request.
	logic [63:0] now_ms = '0;

	upload_retry_tracker u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(drv.command),
		.seq_id(drv.seq_id),
		.payload_crc(drv.payload_crc),
		.oldest_lost(drv.oldest_lost),
		.depth_now(drv.depth_now),
		.payload_len(drv.payload_len),
		.disposition(drv.disposition),
		.http_status(drv.http_status),
		.queue_action(drv.queue_action),
		.random_word(drv.random_word),
		.time_ms(drv.time_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.accepted(accepted),
		.outcome(outcome),
		.busy_res(busy_res),
		.backoff_level(backoff_level),
		.next_try_ms(next_try_ms),
		.depth_seen(depth_seen),
		.enqueued_total(enqueued_total),
		.overflow_total(overflow_total),
		.ack_total(ack_total),
		.retry_total(retry_total),
		.quarantine_total(quarantine_total),
		.last_ok_ms(last_ok_ms),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Event counters stop at their top value instead of wrapping.
	function automatic void count_event(input logic [2:0] slot);
		if (evt_cnt[slot] != ALL_ONES)
			evt_cnt[slot] = evt_cnt[slot] + 32'd1;
	endfunction

	function automatic void forget_request();
		sel_seq = '0;
		sel_crc = '0;
		retry_at = NO_TIME;
		retry_exp = '0;
		req_busy = 1'b0;
		orphaned_req = 1'b0;
	endfunction

	// Applies one command to the tracker state and returns the result it must produce.
	// A command that fails its checks leaves the state alone, except that a well-formed
	// begin head records the depth even when it is refused.
	function automatic result_t advance_tracker(input item_t it);
		result_t r;
		logic took;
		logic [1:0] verdict;
		logic legal;
		logic removal;
		logic [63:0] span;
		took = 1'b0;
		verdict = OUT_IGNORED;
		case (it.command)
			CMD_ENQUEUE: begin
				if (it.depth_now != 0 && it.depth_now <= FIFO_CAPACITY &&
						(it.oldest_lost ? it.seq_id != 0 :
						(it.seq_id == 0 && it.payload_crc == 0))) begin
					took = 1'b1;
					depth_rec = it.depth_now;
					count_event(CNT_ENQUEUED);
					if (it.oldest_lost) begin
						count_event(CNT_OVERFLOW);
						// Losing the held request while it is in flight only marks it;
						// otherwise the request is gone at once.
						if (sel_seq == it.seq_id && sel_crc == it.payload_crc) begin
							if (req_busy)
								orphaned_req = 1'b1;
							else
								forget_request();
						end
					end
				end
			end
			CMD_BEGIN: begin
				if (it.seq_id != 0 && it.payload_len >= MIN_PAYLOAD_LEN &&
						it.payload_len <= tracker_cfg.max_payload_len &&
						it.depth_now != 0 && it.depth_now <= FIFO_CAPACITY &&
						!it.time_ms[63]) begin
					depth_rec = it.depth_now;
					if (!req_busy) begin
						if (sel_seq == it.seq_id && sel_crc == it.payload_crc) begin
							// A retry of the held request waits for its backoff time.
							if (!orphaned_req && !retry_at[63] && it.time_ms >= retry_at) begin
								req_busy = 1'b1;
								took = 1'b1;
							end
						end else begin
							sel_seq = it.seq_id;
							sel_crc = it.payload_crc;
							retry_at = it.time_ms;
							retry_exp = '0;
							req_busy = 1'b1;
							orphaned_req = 1'b0;
							took = 1'b1;
						end
					end
				end
			end
			CMD_RESPONSE: begin
				// The status and queue action must fit the disposition.
				case (it.disposition)
					DISP_ACK: legal = it.http_status >= HTTP_OK_LO &&
						it.http_status <= HTTP_OK_HI && it.queue_action != QA_QUARANTINED;
					DISP_RETRY: legal = it.queue_action == QA_UNCHANGED;
					DISP_QUARANTINE: legal = it.http_status >= HTTP_CLIENT_LO &&
						it.http_status <= HTTP_CLIENT_HI && it.http_status != HTTP_TIMEOUT &&
						it.http_status != HTTP_TOO_MANY && it.queue_action != QA_POPPED;
					default: legal = 1'b0;
				endcase
				if (it.queue_action > QA_QUARANTINED)
					legal = 1'b0;
				// An orphaned request is no longer in the queue, so nothing can be removed.
				if (it.disposition == DISP_RETRY)
					removal = 1'b1;
				else if (orphaned_req)
					removal = it.queue_action == QA_UNCHANGED;
				else if (it.disposition == DISP_ACK)
					removal = it.queue_action == QA_POPPED;
				else
					removal = it.queue_action == QA_QUARANTINED;
				if (req_busy && it.seq_id != 0 && sel_seq == it.seq_id &&
						sel_crc == it.payload_crc && it.depth_now <= FIFO_CAPACITY &&
						!it.time_ms[63] && legal && removal) begin
					depth_rec = it.depth_now;
					if (it.disposition == DISP_ACK) begin
						count_event(CNT_ACK);
						last_ack_ms = it.time_ms;
						forget_request();
						verdict = OUT_ACKED;
					end else if (it.disposition == DISP_QUARANTINE) begin
						if (it.queue_action == QA_QUARANTINED)
							count_event(CNT_QUARANTINE);
						forget_request();
						verdict = OUT_QUARANTINED;
					end else begin
						count_event(CNT_RETRY);
						verdict = OUT_RETRY;
						if (orphaned_req) begin
							forget_request();
						end else begin
							// Capped exponential delay plus masked jitter, saturating
							// at the largest positive time.
							req_busy = 1'b0;
							span = {48'h0, tracker_cfg.base_delay_ms} << retry_exp;
							if (span > {32'h0, tracker_cfg.max_delay_ms})
								span = {32'h0, tracker_cfg.max_delay_ms};
							span = span + {32'h0, it.random_word & tracker_cfg.jitter_mask};
							if (it.time_ms > TIME_MAX - span)
								retry_at = TIME_MAX;
							else
								retry_at = it.time_ms + span;
							if (retry_exp < EXP_CAP)
								retry_exp = retry_exp + 3'd1;
						end
					end
				end
			end
			default: ;
		endcase
		r.accepted = took;
		r.outcome = verdict;
		r.busy = req_busy;
		r.backoff_level = retry_exp;
		r.next_try = retry_at;
		r.depth_seen = depth_rec;
		r.counters = evt_cnt;
		r.last_ok = last_ack_ms[62:0];
		return r;
	endfunction

	// A command with every field random; the builders below overwrite what matters.
	function automatic item_t noise_item();
		item_t it;
		logic [31:0] w;
		w = $urandom;
		it.command = w[1:0];
		it.oldest_lost = w[2];
		it.depth_now = w[10:3];
		it.disposition = w[12:11];
		it.http_status = w[22:13];
		it.queue_action = w[24:23];
		it.seq_id = $urandom;
		it.payload_crc = $urandom;
		w = $urandom;
		it.payload_len = w[15:0];
		it.random_word = $urandom;
		it.time_ms = {$urandom, $urandom};
		return it;
	endfunction

	function automatic item_t enq(input logic dropped, input logic [31:0] sq, cr,
			input logic [7:0] dep);
		item_t it;
		it = noise_item();
		it.command = CMD_ENQUEUE;
		it.oldest_lost = dropped;
		it.seq_id = sq;
		it.payload_crc = cr;
		it.depth_now = dep;
		return it;
	endfunction

	function automatic item_t head(input logic [31:0] sq, cr, input logic [15:0] len,
			input logic [7:0] dep, input logic [63:0] t);
		item_t it;
		it = noise_item();
		it.command = CMD_BEGIN;
		it.seq_id = sq;
		it.payload_crc = cr;
		it.payload_len = len;
		it.depth_now = dep;
		it.time_ms = t;
		return it;
	endfunction

	function automatic item_t resp(input logic [31:0] sq, cr, input logic [1:0] disp,
			input logic [9:0] status, input logic [1:0] action, input logic [7:0] dep,
			input logic [63:0] t);
		item_t it;
		it = noise_item();
		it.command = CMD_RESPONSE;
		it.seq_id = sq;
		it.payload_crc = cr;
		it.disposition = disp;
		it.http_status = status;
		it.queue_action = action;
		it.depth_now = dep;
		it.time_ms = t;
		return it;
	endfunction

	// Mostly a legal depth, sometimes zero or above the queue capacity.
	function automatic logic [7:0] pick_depth();
		logic [31:0] r;
		case ($urandom_range(0, 19))
			0: r = 0;
			1: r = FIFO_CAPACITY + 1;
			2: r = $urandom_range(FIFO_CAPACITY + 1, 255);
			default: r = $urandom_range(1, FIFO_CAPACITY);
		endcase
		return r[7:0];
	endfunction

	function automatic logic [15:0] good_len();
		logic [31:0] r;
		if ($urandom_range(0, 9) != 0)
			r = $urandom_range(MIN_PAYLOAD_LEN, tracker_cfg.max_payload_len);
		else
			r = $urandom;
		return r[15:0];
	endfunction

	// A status that suits the disposition, with the excluded client errors now and then.
	function automatic logic [9:0] status_for(input logic [1:0] disp);
		logic [31:0] r;
		case (disp)
			DISP_ACK: r = $urandom_range(HTTP_OK_LO, HTTP_OK_HI);
			DISP_QUARANTINE: begin
				r = $urandom_range(HTTP_CLIENT_LO, HTTP_CLIENT_HI);
				if ($urandom_range(0, 19) == 0)
					r = {22'd0, ($urandom_range(0, 1) != 0) ? HTTP_TIMEOUT : HTTP_TOO_MANY};
			end
			default: r = $urandom_range(0, STATUS_TOP);
		endcase
		return r[9:0];
	endfunction

	task automatic send(input item_t it);
		cmd_backlog.push_back(it);
		queued_total++;
	endtask

	// Returns once every command has been taken and every result has been checked.
	task automatic drain();
		while (reports_seen != queued_total)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MAX_PAYLOAD_LEN: tracker_cfg.max_payload_len = val[15:0];
			REG_BASE_DELAY_MS: tracker_cfg.base_delay_ms = val[15:0];
			REG_MAX_DELAY_MS: tracker_cfg.max_delay_ms = val;
			default: tracker_cfg.jitter_mask = val;
		endcase
	endtask

	task automatic load_config(input cfg_t c);
		write_reg(REG_MAX_PAYLOAD_LEN, {16'h0, c.max_payload_len});
		write_reg(REG_BASE_DELAY_MS, {16'h0, c.base_delay_ms});
		write_reg(REG_MAX_DELAY_MS, c.max_delay_ms);
		write_reg(REG_JITTER_MASK, c.jitter_mask);
	endtask

	// Random traffic, mostly whole request lifetimes: a begin head, a few retry rounds
	// with their re-begins, and a final ack or quarantine. Mixed in are queue notices,
	// overflow drops of the request, broken responses, early re-begins and pure noise.
	task automatic random_phase(input int count);
		int stop_at;
		int rounds;
		logic [31:0] sq, cr;
		logic dropped_flag;
		logic [1:0] fin;
		logic [1:0] fin_action;
		item_t it;
		stop_at = queued_total + count;
		while (queued_total < stop_at) begin
			if ($urandom_range(0, 99) < 15) begin
				send(noise_item());
			end else begin
				sq = $urandom;
				if (sq == 0)
					sq = 32'd1;
				cr = $urandom;
				dropped_flag = 1'b0;
				if ($urandom_range(0, 99) < 3)
					now_ms = TIME_MAX - $urandom_range(0, 50000);
				else if (now_ms[62])
					now_ms = {32'h0, $urandom};
				else
					now_ms = now_ms + $urandom_range(0, 5000);
				send(head(sq, cr, good_len(), pick_depth(), now_ms));
				rounds = ($urandom_range(0, 7) == 0) ? 9 : $urandom_range(0, 3);
				for (int k = 0; k < rounds; k++) begin
					if ($urandom_range(0, 3) == 0)
						send(enq(1'b0, '0, '0, pick_depth()));
					if ($urandom_range(0, 9) == 0)
						send(enq(1'b1, sq, cr, pick_depth()));
					now_ms = now_ms + $urandom_range(1, 3000);
					send(resp(sq, cr, DISP_RETRY, status_for(DISP_RETRY), QA_UNCHANGED,
						pick_depth(), now_ms));
					// Usually too early for the backoff, then one certainly late enough.
					if ($urandom_range(0, 4) == 0)
						send(head(sq, cr, good_len(), pick_depth(),
							now_ms + $urandom_range(0, 500)));
					now_ms = now_ms + (64'd1 << 34);
					send(head(sq, cr, good_len(), pick_depth(), now_ms));
				end
				if ($urandom_range(0, 9) == 0) begin
					send(enq(1'b1, sq, cr, pick_depth()));
					dropped_flag = 1'b1;
				end
				now_ms = now_ms + $urandom_range(1, 3000);
				if ($urandom_range(0, 4) == 0) begin
					// A response that is wrong in exactly one respect.
					it = resp(sq, cr, DISP_ACK, status_for(DISP_ACK), QA_POPPED,
						pick_depth(), now_ms);
					case ($urandom_range(0, 4))
						0: it.payload_crc = ~cr;
						1: it.time_ms[63] = 1'b1;
						2: it.queue_action = QA_INVALID;
						3: it.disposition = DISP_INVALID;
						default: it.depth_now = FIFO_CAPACITY + 8'd1;
					endcase
					send(it);
				end
				fin = ($urandom_range(0, 2) == 0) ? DISP_QUARANTINE : DISP_ACK;
				if (dropped_flag)
					fin_action = QA_UNCHANGED;
				else
					fin_action = (fin == DISP_ACK) ? QA_POPPED : QA_QUARANTINED;
				if ($urandom_range(0, 9) == 0)
					fin_action = 2'($urandom_range(0, 3));
				send(resp(sq, cr, fin, status_for(fin), fin_action, pick_depth(), now_ms));
			end
		end
	endtask

	// Driver. A new command is offered only once the previous one is taken, so valid
	// and the payload hold steady while the block stalls. Each taken transaction is
	// run through our copy of the tracker right away.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				reports_due.push_back(advance_tracker(drv));
			if (!in_valid || !in_stall) begin
				if (cmd_backlog.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 25)) begin
					drv <= cmd_backlog.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] seen);
		if (want !== seen) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
			errors++;
		end
	endtask

	// Monitor. Each taken result is compared field by field with the oldest one due.
	// Once a fixed number of results has come, the receiver refuses results for a long
	// stretch so that the block fills up and stalls the driver.
	always @(posedge clk) begin : watch_results
		result_t want;
		int hold_left;
		if (arst_n && out_valid && !out_stall) begin
			if (reports_due.size() == 0) begin
				$display("%0t: result with nothing due, outcome %0d accepted %0d",
					$time, outcome, accepted);
				errors++;
			end else begin
				want = reports_due.pop_front();
				check_field("accepted", want.accepted, accepted);
				check_field("outcome", want.outcome, outcome);
				check_field("busy_res", want.busy, busy_res);
				check_field("backoff_level", want.backoff_level, backoff_level);
				check_field("next_try_ms", want.next_try, next_try_ms);
				check_field("depth_seen", want.depth_seen, depth_seen);
				check_field("enqueued_total", want.counters[CNT_ENQUEUED], enqueued_total);
				check_field("overflow_total", want.counters[CNT_OVERFLOW], overflow_total);
				check_field("ack_total", want.counters[CNT_ACK], ack_total);
				check_field("retry_total", want.counters[CNT_RETRY], retry_total);
				check_field("quarantine_total", want.counters[CNT_QUARANTINE],
					quarantine_total);
				check_field("last_ok_ms", want.last_ok, last_ok_ms);
			end
			reports_seen++;
			if (reports_seen == HOLD_AFTER)
				hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !no_gaps && $urandom_range(0, 99) < 25;
		end
	end

	// Watchdog: a run that cannot finish is a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("no finish after %0d cycles", CYCLE_LIMIT);
			$display("tb_upload_retry_tracker: errors");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed commands under the reset configuration.
		// A response with nothing in flight and an unknown command change nothing.
		send(resp(SEQ_A, CRC_A, DISP_ACK, HTTP_OK_LO, QA_POPPED, 8'd1, 64'd0));
		begin : unknown_cmd
			item_t it;
			it = noise_item();
			it.command = CMD_UNKNOWN;
			send(it);
		end
		// Enqueue notices: a plain one, depths zero and above capacity, a drop without
		// a sequence, and a plain notice that names a request.
		send(enq(1'b0, '0, '0, 8'd1));
		send(enq(1'b0, '0, '0, 8'd0));
		send(enq(1'b0, '0, '0, FIFO_CAPACITY + 8'd1));
		send(enq(1'b1, '0, CRC_A, 8'd5));
		send(enq(1'b0, SEQ_A, '0, 8'd5));
		// Begin head refused for a short payload, a long payload and a negative time.
		send(head(SEQ_A, CRC_A, 16'd1, 8'd4, 64'd1000));
		send(head(SEQ_A, CRC_A, 16'd4097, 8'd4, 64'd1000));
		send(head(SEQ_A, CRC_A, 16'd100, 8'd4, 64'h8000_0000_0000_0000));
		send(head(SEQ_A, CRC_A, MIN_PAYLOAD_LEN, FIFO_CAPACITY, 64'd1000));
		// A second head while one is in flight records the depth but is refused.
		send(head(SEQ_B, CRC_B, 16'd4096, 8'd7, 64'd1001));
		// Responses with an invalid queue action or disposition are ignored.
		send(resp(SEQ_A, CRC_A, DISP_RETRY, 10'd503, QA_INVALID, 8'd3, 64'd1100));
		send(resp(SEQ_A, CRC_A, DISP_INVALID, HTTP_OK_LO, QA_POPPED, 8'd3, 64'd1100));
		send(resp(SEQ_A, CRC_A, DISP_RETRY, 10'd503, QA_UNCHANGED, 8'd0, 64'd2000));
		// The retry comes too early, then late enough.
		send(head(SEQ_A, CRC_A, MIN_PAYLOAD_LEN, 8'd1, 64'd2001));
		send(head(SEQ_A, CRC_A, MIN_PAYLOAD_LEN, 8'd1, 64'd10_000_000));
		// The queue drops the request in flight; the ack then may not pop it.
		send(enq(1'b1, SEQ_A, CRC_A, FIFO_CAPACITY));
		send(resp(SEQ_A, CRC_A, DISP_ACK, HTTP_OK_HI, QA_UNCHANGED, 8'd2, 64'd10_000_500));
		// Largest identifiers near the end of time: the retry time saturates, and a
		// drop of the waiting request forgets it.
		send(head(ALL_ONES, ALL_ONES, 16'd4096, 8'd2, TIME_MAX - 64'd5));
		send(resp(ALL_ONES, ALL_ONES, DISP_RETRY, STATUS_TOP, QA_UNCHANGED, FIFO_CAPACITY,
			TIME_MAX - 64'd4));
		send(enq(1'b1, ALL_ONES, ALL_ONES, 8'd1));
		// Quarantine refused for a timeout status, then taken.
		send(head(SEQ_B, CRC_B, 16'd50, 8'd9, 64'd5000));
		send(resp(SEQ_B, CRC_B, DISP_QUARANTINE, HTTP_TIMEOUT, QA_QUARANTINED, 8'd9,
			64'd5001));
		send(resp(SEQ_B, CRC_B, DISP_QUARANTINE, 10'd404, QA_QUARANTINED, 8'd8, 64'd5002));
		// Negative time and an oversized depth are ignored before the clean ack.
		send(head(SEQ_B, CRC_B, 16'd50, 8'd9, 64'd5003));
		send(resp(SEQ_B, CRC_B, DISP_ACK, HTTP_OK_LO, QA_POPPED, 8'd1, {1'b1, 63'd6000}));
		send(resp(SEQ_B, CRC_B, DISP_ACK, HTTP_OK_LO, QA_POPPED, 8'd255, 64'd6000));
		send(resp(SEQ_B, CRC_B, DISP_ACK, 10'd250, QA_POPPED, 8'd0, 64'd6000));
		drain();

		// Random traffic under several settings, the extremes first. The third phase
		// runs with neither side idling.
		load_config('{max_payload_len: MIN_PAYLOAD_LEN, base_delay_ms: 16'd0,
			max_delay_ms: 32'd0, jitter_mask: 32'd0});
		random_phase(190);
		drain();
		load_config('{max_payload_len: 16'hFFFF, base_delay_ms: 16'hFFFF,
			max_delay_ms: ALL_ONES, jitter_mask: ALL_ONES});
		random_phase(190);
		drain();
		begin : random_settings
			cfg_t c;
			logic [31:0] w;
			w = $urandom_range(MIN_PAYLOAD_LEN, 16'hFFFF);
			c.max_payload_len = w[15:0];
			w = $urandom;
			c.base_delay_ms = w[15:0];
			c.max_delay_ms = $urandom;
			c.jitter_mask = $urandom;
			load_config(c);
		end
		no_gaps = 1'b1;
		random_phase(180);
		drain();
		no_gaps = 1'b0;
		load_config('{max_payload_len: 16'd300, base_delay_ms: 16'd1000,
			max_delay_ms: 32'd5000, jitter_mask: 32'd255});
		random_phase(190);
		drain();

		repeat (END_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_upload_retry_tracker: clean");
		else
			$display("tb_upload_retry_tracker: errors");
		$finish;
	end

endmodule
